FILE: src/bitset_with_min_tracking_assert.svh
`ifndef BITSET_WITH_MIN_TRACKING_ASSERT_SVH
`define BITSET_WITH_MIN_TRACKING_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define BWMT_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bwmt: same-cycle check failed");

// next-cycle implication, sampled on clk, off during reset
`define BWMT_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bwmt: next-cycle check failed");

`endif

FILE: src/bwmt_pkg.sv
package bwmt_pkg;

	localparam int SIZE_W = 11;
	localparam int ELEM_W = 10;
	localparam int OP_W   = 2;

	localparam int MAX_ELEMENTS_DEF = 1024;
	localparam int SEG_BITS_DEF     = 32;

	localparam logic [SIZE_W-1:0] MAX_SIZE_RST = 11'd1024;

	typedef enum logic [OP_W-1:0] {
		OP_ADD,
		OP_DEL,
		OP_QUERY,
		OP_CLEAR
	} bwmt_op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOKUP,
		ST_SCAN_RD,
		ST_SCAN_CHK
	} bwmt_state_t;

	typedef struct packed {
		logic [OP_W-1:0]   req_type;
		logic [ELEM_W-1:0] element;
	} bwmt_req_t;

	typedef struct packed {
		logic              was_member;
		logic [SIZE_W-1:0] smallest;
		logic [SIZE_W-1:0] member_count;
		logic              range_error;
	} bwmt_rsp_t;

endpackage

FILE: src/bitset_with_min_tracking.sv
// Integer set held as a bitmap of rows in a single-port-per-side RAM, with the
// smallest member and the member count kept in registers. A transaction is
// accepted when start is high and busy is low; its result appears on result
// for exactly one cycle with done high and must be sampled then, since the
// receiver cannot stall the block. Clear and out-of-range requests are
// finished in the idle state; add, delete and query take one RAM read, then
// the read-modify-write in the lookup state. Deleting the current smallest
// member may start a rescan that walks the rows above it through the same RAM
// read port and the same find-first-set unit, each row read in the scan-read
// state and checked in the scan-check state. busy is high only in the lookup
// and scan states, and a new transaction may be accepted in the done
// cycle. Writing cfg_data with cfg_we (only while idle) sets max_size and
// empties the set; max_size above MAX_ELEMENTS acts as MAX_ELEMENTS. Clearing,
// whether by reset, a clear request or a size write, takes effect at once:
// each RAM row has a valid flag, and a row never written since reads as zero,
// so there is no clearing pass.
module bitset_with_min_tracking #(
	parameter int MAX_ELEMENTS = bwmt_pkg::MAX_ELEMENTS_DEF,
	parameter int SEG_BITS     = bwmt_pkg::SEG_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  bwmt_pkg::bwmt_req_t            request,
	input  logic                           cfg_we,
	input  logic [bwmt_pkg::SIZE_W-1:0]    cfg_data,
	output logic                           done,
	output bwmt_pkg::bwmt_rsp_t            result
);

	// Row width is SEG_BITS rounded up to a power of two so that an element
	// splits into row and bit position by plain bit slicing.
	localparam int BIT_W    = $clog2(SEG_BITS);
	localparam int ROW_W    = 1 << BIT_W;
	localparam int NUM_SEGS = (MAX_ELEMENTS + ROW_W - 1) / ROW_W;
	localparam int SEG_AW   = (NUM_SEGS > 1) ? $clog2(NUM_SEGS) : 1;
	localparam int CNT_W    = $clog2(MAX_ELEMENTS + 1);
	localparam int SIZE_W   = bwmt_pkg::SIZE_W;
	localparam int ELEM_W   = bwmt_pkg::ELEM_W;

	localparam logic [SEG_AW-1:0] LAST_SEG = SEG_AW'(NUM_SEGS - 1);
	localparam logic [SIZE_W-1:0] EFF_RST  =
		(MAX_ELEMENTS < int'(bwmt_pkg::MAX_SIZE_RST)) ? SIZE_W'(MAX_ELEMENTS)
		                                              : bwmt_pkg::MAX_SIZE_RST;

	// size actually in force: max_size saturated at MAX_ELEMENTS
	function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v);
		return (int'(v) > MAX_ELEMENTS) ? SIZE_W'(MAX_ELEMENTS) : v;
	endfunction

	// lowest set bit position; caller checks that any bit is set
	function automatic logic [BIT_W-1:0] first_set(input logic [ROW_W-1:0] v);
		logic [BIT_W-1:0] pos;
		pos = '0;
		for (int i = ROW_W - 1; i >= 0; i--) begin
			if (v[i]) begin
				pos = BIT_W'(i);
			end
		end
		return pos;
	endfunction

	// control state
	bwmt_pkg::bwmt_state_t state_q, state_d;
	logic                  done_q;
	logic [NUM_SEGS-1:0]   valid_q;      // row written since last clear
	logic [SIZE_W-1:0]     eff_q;        // effective size
	logic [SIZE_W-1:0]     smallest_q;
	logic [CNT_W-1:0]      pop_q;
	logic                  was_q;
	logic                  err_q;

	// transaction held across the lookup and the scan
	bwmt_pkg::bwmt_op_t    op_q;
	logic [ELEM_W-1:0]     elem_q;
	logic [SEG_AW-1:0]     seg_q;
	logic [BIT_W-1:0]      bpos_q;
	logic [SEG_AW-1:0]     scan_q;

	// request decode
	logic                  accept;
	bwmt_pkg::bwmt_op_t    req_op;
	logic                  in_range;
	logic [SEG_AW-1:0]     in_seg;
	logic [BIT_W-1:0]      in_bpos;

	// row datapath
	logic [SEG_AW-1:0]     rd_addr;
	logic [ROW_W-1:0]      ram_rdata;
	logic [SEG_AW-1:0]     cur_seg;
	logic [ROW_W-1:0]      row_rd;
	logic [ROW_W-1:0]      bit_mask;
	logic [ROW_W-1:0]      new_row;
	logic                  was;
	logic                  row_we;
	logic                  del_scan;   // deleting the smallest member

	// shared find-first-set unit
	logic [ROW_W-1:0]      ffs_in;
	logic                  ffs_any;
	logic [SIZE_W-1:0]     found;

	assign accept   = start && (state_q == bwmt_pkg::ST_IDLE);
	assign req_op   = bwmt_pkg::bwmt_op_t'(request.req_type);
	assign in_range = SIZE_W'(request.element) < eff_q;
	assign in_seg   = SEG_AW'(request.element >> BIT_W);
	assign in_bpos  = request.element[BIT_W-1:0];

	// Rows not written since the last clear read as empty.
	assign cur_seg  = (state_q == bwmt_pkg::ST_LOOKUP) ? seg_q : scan_q;
	assign row_rd   = valid_q[cur_seg] ? ram_rdata : '0;
	assign bit_mask = ROW_W'(1) << bpos_q;
	assign was      = |(row_rd & bit_mask);
	assign new_row  = (op_q == bwmt_pkg::OP_ADD) ? (row_rd | bit_mask)
	                                             : (row_rd & ~bit_mask);
	assign del_scan = (op_q == bwmt_pkg::OP_DEL) && (SIZE_W'(elem_q) == smallest_q);

	assign ffs_any  = |ffs_in;
	assign found    = SIZE_W'({cur_seg, first_set(ffs_in)});

	bwmt_ram #(
		.WIDTH (ROW_W),
		.DEPTH (NUM_SEGS)
	) u_ram (
		.clk   (clk),
		.we    (row_we),
		.waddr (seg_q),
		.wdata (new_row),
		.raddr (rd_addr),
		.rdata (ram_rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bwmt_pkg::ST_IDLE: begin
				if (accept && (req_op != bwmt_pkg::OP_CLEAR) && in_range) begin
					state_d = bwmt_pkg::ST_LOOKUP;
				end
			end
			bwmt_pkg::ST_LOOKUP: begin
				// the updated row itself holds no member: walk the rows above
				if (del_scan && !ffs_any && (seg_q != LAST_SEG)) begin
					state_d = bwmt_pkg::ST_SCAN_RD;
				end else begin
					state_d = bwmt_pkg::ST_IDLE;
				end
			end
			bwmt_pkg::ST_SCAN_RD: begin
				state_d = bwmt_pkg::ST_SCAN_CHK;
			end
			bwmt_pkg::ST_SCAN_CHK: begin
				if (!ffs_any && (scan_q != LAST_SEG)) begin
					state_d = bwmt_pkg::ST_SCAN_RD;
				end else begin
					state_d = bwmt_pkg::ST_IDLE;
				end
			end
		endcase
	end

	// per-state datapath controls
	always_comb begin
		rd_addr = scan_q;
		row_we  = 1'b0;
		ffs_in  = row_rd;
		unique case (state_q)
			bwmt_pkg::ST_IDLE: begin
				rd_addr = in_seg;
			end
			bwmt_pkg::ST_LOOKUP: begin
				ffs_in = new_row;
				row_we = ((op_q == bwmt_pkg::OP_ADD) && !was) ||
				         ((op_q == bwmt_pkg::OP_DEL) && was);
			end
			bwmt_pkg::ST_SCAN_RD: begin
				rd_addr = scan_q;
			end
			bwmt_pkg::ST_SCAN_CHK: begin
				ffs_in = row_rd;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= bwmt_pkg::ST_IDLE;
			done_q     <= 1'b0;
			valid_q    <= '0;
			eff_q      <= EFF_RST;
			smallest_q <= EFF_RST;
			pop_q      <= '0;
			was_q      <= 1'b0;
			err_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= 1'b0;
			unique case (state_q)
				bwmt_pkg::ST_IDLE: begin
					if (accept) begin
						if (req_op == bwmt_pkg::OP_CLEAR) begin
							valid_q    <= '0;
							pop_q      <= '0;
							smallest_q <= eff_q;
							was_q      <= 1'b0;
							err_q      <= 1'b0;
							done_q     <= 1'b1;
						end else if (!in_range) begin
							was_q  <= 1'b0;
							err_q  <= 1'b1;
							done_q <= 1'b1;
						end
					end
				end
				bwmt_pkg::ST_LOOKUP: begin
					was_q <= was;
					err_q <= 1'b0;
					if (row_we) begin
						valid_q[seg_q] <= 1'b1;
					end
					if (op_q == bwmt_pkg::OP_ADD) begin
						if (!was) begin
							pop_q <= pop_q + CNT_W'(1);
						end
						if (SIZE_W'(elem_q) < smallest_q) begin
							smallest_q <= SIZE_W'(elem_q);
						end
						done_q <= 1'b1;
					end else if (op_q == bwmt_pkg::OP_DEL) begin
						if (was) begin
							pop_q <= pop_q - CNT_W'(1);
						end
						if (!del_scan) begin
							done_q <= 1'b1;
						end else if (ffs_any) begin
							smallest_q <= found;
							done_q     <= 1'b1;
						end else if (seg_q == LAST_SEG) begin
							smallest_q <= eff_q;
							done_q     <= 1'b1;
						end
					end else begin
						done_q <= 1'b1;
					end
				end
				bwmt_pkg::ST_SCAN_RD: begin
					done_q <= 1'b0;
				end
				bwmt_pkg::ST_SCAN_CHK: begin
					if (ffs_any) begin
						smallest_q <= found;
						done_q     <= 1'b1;
					end else if (scan_q == LAST_SEG) begin
						// no member left
						smallest_q <= eff_q;
						done_q     <= 1'b1;
					end
				end
			endcase
			// size write empties the set; user issues it only while idle, not enforced
			if (cfg_we) begin
				eff_q      <= clamp_size(cfg_data);
				smallest_q <= clamp_size(cfg_data);
				pop_q      <= '0;
				valid_q    <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= req_op;
			elem_q <= request.element;
			seg_q  <= in_seg;
			bpos_q <= in_bpos;
		end
		if (state_q == bwmt_pkg::ST_LOOKUP) begin
			scan_q <= seg_q + SEG_AW'(1);
		end else if (state_q == bwmt_pkg::ST_SCAN_CHK) begin
			scan_q <= scan_q + SEG_AW'(1);
		end
	end

	assign busy = (state_q != bwmt_pkg::ST_IDLE);
	assign done = done_q;

	always_comb begin
		result.was_member   = was_q;
		result.smallest     = smallest_q;
		result.member_count = SIZE_W'(pop_q);
		result.range_error  = err_q;
	end

endmodule

FILE: src/bwmt_ram.sv
module bwmt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: src/bitset_with_min_tracking_chk.sv
`include "bitset_with_min_tracking_assert.svh"

module bitset_with_min_tracking_chk (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        start,
	input logic                        busy,
	input logic                        done,
	input bwmt_pkg::bwmt_rsp_t         result
);

	// an accepted transaction either finishes next cycle or keeps the block busy
	`BWMT_ASSERT_NEXT(a_accept_progress, start && !busy, busy || done)

	// a result only follows an accept or a busy cycle
	`BWMT_ASSERT_SAME(a_done_source, done, $past(start && !busy) || $past(busy))

	// busy only starts on an accepted transaction
	`BWMT_ASSERT_SAME(a_busy_source, $rose(busy), $past(start))

	// a rejected element is never reported as a member
	`BWMT_ASSERT_SAME(a_err_not_member, done && result.range_error, !result.was_member)

endmodule

bind bitset_with_min_tracking bitset_with_min_tracking_chk u_bwmt_chk (.*);
